@@ rtl/slotted_csma_cd_node_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slotted CSMA/CD node engine
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SLOTTED_CSMA_CD_NODE_ENGINE_ASSERT_SVH
`define SLOTTED_CSMA_CD_NODE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define SCCD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sccd_pkg.sv @@
// ----------------------------------------------------------------------------
// sccd_pkg
// Types and constants shared by the slotted CSMA/CD node engine.
// ----------------------------------------------------------------------------
package sccd_pkg;

    // Node phase codes as reported on the result channel.
    typedef enum logic [2:0] {
        PH_DROP    = 3'd0,
        PH_BACKOFF = 3'd1,
        PH_SENSE   = 3'd2,
        PH_TX      = 3'd3,
        PH_ACK     = 3'd4,
        PH_TIMEOUT = 3'd5
    } phase_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_EXPONENT      = 2'd0;
    localparam logic [1:0] REG_MAX_EXPONENT      = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT_SLOTS = 2'd2;

    localparam int RAND_W = 10;
    localparam int EXP_W  = 4;
    localparam int TX_W   = 5;
    localparam int ACK_W  = 3;
    localparam int TO_W   = 4;
    localparam int BUSY_W = 16;
    localparam int CNT_W  = 32;

    typedef struct packed {
        logic [EXP_W-1:0] min_exponent;
        logic [EXP_W-1:0] max_exponent;
        logic [TO_W-1:0]  ack_timeout_slots;
    } cfg_t;

    // One node's stored entry.
    typedef struct packed {
        phase_t            phase;
        logic [EXP_W-1:0]  exponent;
        logic [RAND_W-1:0] backoff_left;
        logic              sense_ready;
        logic [TO_W-1:0]   timeout_left;
        logic [TX_W-1:0]   tx_left;
        logic [ACK_W-1:0]  ack_left;
    } node_entry_t;

    // Effects of one visit on the shared counters.
    typedef struct packed {
        logic busy_inc;
        logic busy_dec;
        logic success;
        logic failure;
    } step_events_t;

    // Keep the low k bits of a draw; k of ten or more keeps all of it.
    function automatic logic [RAND_W-1:0] draw_bits(logic [RAND_W-1:0] r,
                                                    logic [EXP_W:0] k);
        logic [RAND_W-1:0] mask;
        for (int i = 0; i < RAND_W; i++) begin
            mask[i] = ((EXP_W+1)'(i) < k);
        end
        return r & mask;
    endfunction

endpackage

@@ rtl/sccd_node_step.sv @@
// ----------------------------------------------------------------------------
// sccd_node_step
// Next-state logic for one visit to one node.
// ----------------------------------------------------------------------------
module sccd_node_step #(
    parameter int TX_SLOTS  = 10,
    parameter int ACK_SLOTS = 2
) (
    input  sccd_pkg::cfg_t                     cfg,
    input  logic                               started,
    input  sccd_pkg::node_entry_t              entry_in,
    input  logic [sccd_pkg::RAND_W-1:0]        rand_start,
    input  logic [sccd_pkg::RAND_W-1:0]        rand_retry,
    input  logic signed [sccd_pkg::BUSY_W-1:0] busy_latched,
    output sccd_pkg::node_entry_t              entry_out,
    output logic                               started_out,
    output sccd_pkg::step_events_t             events
);

    localparam logic [sccd_pkg::TX_W-1:0]  TX_INIT  = sccd_pkg::TX_W'(TX_SLOTS);
    localparam logic [sccd_pkg::ACK_W-1:0] ACK_INIT = sccd_pkg::ACK_W'(ACK_SLOTS);

    sccd_pkg::node_entry_t         cur;
    logic [sccd_pkg::EXP_W:0]      k_retry;
    logic                          latched_zero;
    logic                          latched_one;

    always_comb begin
        // A node that has not started loads a fresh entry before stepping.
        cur = entry_in;
        if (!started) begin
            cur.exponent     = cfg.min_exponent;
            cur.backoff_left = sccd_pkg::draw_bits(rand_start, {1'b0, cfg.min_exponent});
            cur.timeout_left = cfg.ack_timeout_slots;
            cur.sense_ready  = 1'b1;
            cur.tx_left      = TX_INIT;
            cur.ack_left     = ACK_INIT;
            cur.phase        = (cur.backoff_left == '0) ? sccd_pkg::PH_SENSE
                                                        : sccd_pkg::PH_BACKOFF;
        end

        latched_zero = (busy_latched == '0);
        latched_one  = (busy_latched == sccd_pkg::BUSY_W'(1));
        k_retry      = {1'b0, cur.exponent} + (sccd_pkg::EXP_W+1)'(1);

        entry_out   = cur;
        started_out = started;
        events      = '0;

        case (cur.phase)
            sccd_pkg::PH_BACKOFF: begin
                started_out = 1'b1;
                if (cur.backoff_left == '0) begin
                    entry_out.phase = sccd_pkg::PH_SENSE;
                end else begin
                    entry_out.backoff_left = cur.backoff_left - sccd_pkg::RAND_W'(1);
                end
            end
            sccd_pkg::PH_SENSE: begin
                started_out = 1'b1;
                if (cur.sense_ready && latched_zero) begin
                    entry_out.sense_ready = 1'b0;
                    entry_out.phase       = sccd_pkg::PH_TX;
                    events.busy_inc       = 1'b1;
                end else begin
                    entry_out.exponent = k_retry[sccd_pkg::EXP_W-1:0];
                    if (k_retry <= {1'b0, cfg.max_exponent}) begin
                        entry_out.backoff_left = sccd_pkg::draw_bits(rand_retry, k_retry);
                        entry_out.phase        = sccd_pkg::PH_BACKOFF;
                    end else begin
                        entry_out.phase = sccd_pkg::PH_DROP;
                    end
                end
            end
            sccd_pkg::PH_TX: begin
                if (cur.tx_left != TX_INIT && cur.tx_left == sccd_pkg::TX_W'(1)) begin
                    entry_out.phase = sccd_pkg::PH_ACK;
                    events.busy_dec = 1'b1;
                end else begin
                    entry_out.tx_left = cur.tx_left - sccd_pkg::TX_W'(1);
                end
            end
            sccd_pkg::PH_ACK: begin
                if (latched_zero) begin
                    events.busy_inc = 1'b1;
                end else if (latched_one) begin
                    if (cur.ack_left != ACK_INIT && cur.ack_left == sccd_pkg::ACK_W'(1)) begin
                        events.busy_dec = 1'b1;
                        events.success  = 1'b1;
                        started_out     = 1'b0;
                    end else begin
                        entry_out.ack_left = cur.ack_left - sccd_pkg::ACK_W'(1);
                    end
                end else begin
                    entry_out.phase = sccd_pkg::PH_TIMEOUT;
                end
            end
            sccd_pkg::PH_TIMEOUT: begin
                if (cur.timeout_left == sccd_pkg::TO_W'(1)) begin
                    events.failure  = 1'b1;
                    events.busy_dec = 1'b1;
                    started_out     = 1'b0;
                end else begin
                    entry_out.timeout_left = cur.timeout_left - sccd_pkg::TO_W'(1);
                    entry_out.phase        = sccd_pkg::PH_ACK;
                end
            end
            default: begin
                // A dropped node stays as it is.
            end
        endcase
    end

endmodule

@@ rtl/slotted_csma_cd_node_engine.sv @@
// ----------------------------------------------------------------------------
// slotted_csma_cd_node_engine
// Slotted CSMA/CD node engine with binary exponential backoff.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   -------   ---------  -----------------  ---------------------------------
//   s_        in         s_valid/s_ready    rand_start, rand_retry
//   m_        out        m_valid/m_ready    node_index, node_phase, slot_done,
//                                           channel_busy, successes,
//                                           failures, attempts
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One input transfer is taken every cycle while s_ready is high; each
// produces one result. Acceptance reads the visited node's entry from the
// node memory (registered read) into the visit stage, which then runs the
// visit logic and loads the result register. Reset (synchronous, active
// low) needs no clearing pass: the started bits live in flip-flops. A
// stall on the result side fills the visit stage and then holds s_ready low.
//
// Each input transfer visits the next node in round-robin order. A full
// pass over the nodes forms one slot; after its last node the shared busy
// count is latched into the channel-busy value seen by the next slot.
// ----------------------------------------------------------------------------
module slotted_csma_cd_node_engine #(
    parameter int NUM_NODES = 16,
    parameter int TX_SLOTS  = 10,
    parameter int ACK_SLOTS = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [3:0]                         cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [9:0]                         s_rand_start,
    input  logic [9:0]                         s_rand_retry,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3:0]                         m_node_index,
    output logic [2:0]                         m_node_phase,
    output logic                               m_slot_done,
    output logic signed [15:0]                 m_channel_busy,
    output logic [31:0]                        m_successes,
    output logic [31:0]                        m_failures,
    output logic [31:0]                        m_attempts
);

    localparam int NODE_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NUM_NODES - 1);

    // Configuration registers.
    sccd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_exponent      <= 4'd3;
            cfg_reg.max_exponent      <= 4'd5;
            cfg_reg.ack_timeout_slots <= 4'd3;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sccd_pkg::REG_MIN_EXPONENT:      cfg_reg.min_exponent      <= cfg_wdata;
                sccd_pkg::REG_MAX_EXPONENT:      cfg_reg.max_exponent      <= cfg_wdata;
                sccd_pkg::REG_ACK_TIMEOUT_SLOTS: cfg_reg.ack_timeout_slots <= cfg_wdata;
                default: begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    // Handshake control. The visit stage fires when the result register is
    // free or is being emptied in the same cycle.
    logic                   visit_valid_reg;
    logic                   out_valid_reg;
    logic                   s_xfer;
    logic                   visit_fire;

    assign visit_fire = visit_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !visit_valid_reg || visit_fire;
    assign s_xfer     = s_valid && s_ready;

    // Issue pointer: the node the next accepted transfer will visit.
    logic [NODE_W-1:0]      ptr_reg;
    logic [NODE_W-1:0]      ptr_next;

    assign ptr_next = (ptr_reg == LAST_NODE) ? '0 : ptr_reg + NODE_W'(1);

    // Visit stage registers.
    logic [NODE_W-1:0]      node_reg;
    logic [9:0]             rand_start_reg;
    logic [9:0]             rand_retry_reg;

    // Node memory with registered read. When the entry being read is the
    // one written in the same cycle (only with a single node), the freshly
    // written entry is forwarded instead.
    sccd_pkg::node_entry_t  node_mem [NUM_NODES];
    sccd_pkg::node_entry_t  rd_data_reg;
    sccd_pkg::node_entry_t  fwd_data_reg;
    logic                   fwd_reg;
    sccd_pkg::node_entry_t  entry_cur;
    sccd_pkg::node_entry_t  entry_next;

    assign entry_cur = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (visit_fire) begin
            node_mem[node_reg] <= entry_next;
        end
        if (s_xfer) begin
            rd_data_reg  <= node_mem[ptr_reg];
            fwd_data_reg <= entry_next;
        end
    end

    // Started bits are cleared by reset, so unwritten entries are never used.
    logic [NUM_NODES-1:0]   started_reg;
    logic                   started_cur;
    logic                   started_upd;
    sccd_pkg::step_events_t events;

    assign started_cur = started_reg[node_reg];

    // Shared counters.
    logic signed [15:0]     busy_count_reg;
    logic signed [15:0]     busy_count_next;
    logic signed [15:0]     busy_latched_reg;
    logic [31:0]            success_total_reg;
    logic [31:0]            failure_total_reg;
    logic [31:0]            attempt_total_reg;
    logic                   last_visit;

    assign last_visit = (node_reg == LAST_NODE);

    always_comb begin
        busy_count_next = busy_count_reg;
        if (events.busy_inc) begin
            busy_count_next = busy_count_reg + 16'sd1;
        end else if (events.busy_dec) begin
            busy_count_next = busy_count_reg - 16'sd1;
        end
    end

    sccd_node_step #(
        .TX_SLOTS  (TX_SLOTS),
        .ACK_SLOTS (ACK_SLOTS)
    ) u_step (
        .cfg          (cfg_reg),
        .started      (started_cur),
        .entry_in     (entry_cur),
        .rand_start   (rand_start_reg),
        .rand_retry   (rand_retry_reg),
        .busy_latched (busy_latched_reg),
        .entry_out    (entry_next),
        .started_out  (started_upd),
        .events       (events)
    );

    // Result payload registers.
    logic [3:0]             out_node_index_reg;
    sccd_pkg::phase_t       out_phase_reg;
    logic                   out_slot_done_reg;
    logic [31:0]            node_wide;

    assign node_wide = 32'(node_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visit_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            ptr_reg           <= '0;
            fwd_reg           <= 1'b0;
            started_reg       <= '0;
            busy_count_reg    <= '0;
            busy_latched_reg  <= '0;
            success_total_reg <= '0;
            failure_total_reg <= '0;
            attempt_total_reg <= '0;
        end else begin
            if (s_xfer) begin
                visit_valid_reg <= 1'b1;
                ptr_reg         <= ptr_next;
                fwd_reg         <= visit_fire && (node_reg == ptr_reg);
            end else if (visit_fire) begin
                visit_valid_reg <= 1'b0;
            end

            if (visit_fire) begin
                out_valid_reg         <= 1'b1;
                started_reg[node_reg] <= started_upd;
                busy_count_reg        <= busy_count_next;
                if (last_visit) begin
                    busy_latched_reg <= busy_count_next;
                end
                if (events.success) begin
                    success_total_reg <= success_total_reg + 32'd1;
                end
                if (events.failure) begin
                    failure_total_reg <= failure_total_reg + 32'd1;
                end
                if (events.success || events.failure) begin
                    attempt_total_reg <= attempt_total_reg + 32'd1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            node_reg       <= ptr_reg;
            rand_start_reg <= s_rand_start;
            rand_retry_reg <= s_rand_retry;
        end
        if (visit_fire) begin
            out_node_index_reg <= node_wide[3:0];
            out_phase_reg      <= entry_next.phase;
            out_slot_done_reg  <= last_visit;
        end
    end

    // The shared counters change only when a new result is loaded, so they
    // drive the result ports directly.
    assign m_valid        = out_valid_reg;
    assign m_node_index   = out_node_index_reg;
    assign m_node_phase   = out_phase_reg;
    assign m_slot_done    = out_slot_done_reg;
    assign m_channel_busy = busy_latched_reg;
    assign m_successes    = success_total_reg;
    assign m_failures     = failure_total_reg;
    assign m_attempts     = attempt_total_reg;

endmodule

@@ rtl/sccd_checker.sv @@
// ----------------------------------------------------------------------------
// sccd_checker
// Port-level assertions for the slotted CSMA/CD node engine.
// ----------------------------------------------------------------------------
`include "slotted_csma_cd_node_engine_assert.svh"

module sccd_checker #(
    parameter int NUM_NODES = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_node_index,
    input logic [2:0]  m_node_phase,
    input logic        m_slot_done,
    input logic [15:0] m_channel_busy,
    input logic [31:0] m_successes,
    input logic [31:0] m_failures,
    input logic [31:0] m_attempts
);

    localparam logic [31:0] LAST_NODE_WIDE = 32'(NUM_NODES - 1);

    logic [31:0] outcome_sum;

    assign outcome_sum = m_successes + m_failures;

    // A stalled result keeps its payload.
    `SCCD_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_node_index) && $stable(m_node_phase) &&
        $stable(m_channel_busy) && $stable(m_attempts),
        "result changed while stalled")

    // Every finished attempt is either a success or a failure.
    `SCCD_ASSERT_NOW(a_attempt_total, aclk, aresetn, m_valid,
        m_attempts == outcome_sum, "attempt total differs from outcomes")

    // The slot ends on the last node.
    `SCCD_ASSERT_NOW(a_slot_end_node, aclk, aresetn, m_valid && m_slot_done,
        m_node_index == LAST_NODE_WIDE[3:0], "slot ended on the wrong node")

    // Reset leaves no result pending.
    `SCCD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid,
        "result valid right after reset")

endmodule

bind slotted_csma_cd_node_engine sccd_checker #(
    .NUM_NODES (NUM_NODES)
) u_sccd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_node_index   (m_node_index),
    .m_node_phase   (m_node_phase),
    .m_slot_done    (m_slot_done),
    .m_channel_busy (m_channel_busy),
    .m_successes    (m_successes),
    .m_failures     (m_failures),
    .m_attempts     (m_attempts)
);
